[hdl/twc_pkg.sv]
// ----------------------------------------------------------------------------
// twc_pkg
// Shared types and constants of the time binned window counter.
// ----------------------------------------------------------------------------
package twc_pkg;

    // Field widths of the stream beats and the configuration registers.
    localparam int NOW_W      = 48;
    localparam int AMT_W      = 32;
    localparam int OUT_W      = 32;
    localparam int BIN_OUT_W  = 6;
    localparam int LEN_W      = 32;
    localparam int WCFG_W     = 7;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 72;

    // Divider geometry: a 48 bit dividend over a 32 bit divisor.
    localparam int DIV_NUM_W  = NOW_W;
    localparam int DIV_DEN_W  = LEN_W;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 1'b1;

    // Register reset values.
    localparam logic [LEN_W-1:0]  BIN_LENGTH_RST  = 32'd1000000;
    localparam logic [WCFG_W-1:0] BINS_IN_USE_RST = 7'd64;

    typedef enum logic [3:0] {
        ST_WIPE,
        ST_IDLE,
        ST_DIV_Q,
        ST_DIV_R,
        ST_ADVANCE,
        ST_READ,
        ST_WRITE,
        ST_SUM,
        ST_SUM_LAST,
        ST_DONE
    } twc_state_t;

    // Control of the sum and minimum accumulator.
    typedef struct packed {
        logic clear;
        logic add;
    } acc_ctrl_t;

endpackage

[hdl/twc_ram.sv]
// ----------------------------------------------------------------------------
// twc_ram
// Bin count memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module twc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/twc_div.sv]
// ----------------------------------------------------------------------------
// twc_div
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// ----------------------------------------------------------------------------
module twc_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [twc_pkg::DIV_NUM_W-1:0]   num,
    input  logic [twc_pkg::DIV_DEN_W-1:0]   den,
    output logic                            done,
    output logic [twc_pkg::DIV_NUM_W-1:0]   quot,
    output logic [twc_pkg::DIV_DEN_W-1:0]   rem
);

    localparam int NW = twc_pkg::DIV_NUM_W;
    localparam int DW = twc_pkg::DIV_DEN_W;
    localparam int CW = twc_pkg::DIV_CNT_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic [NW-1:0] quot_reg, quot_next;
    logic [DW-1:0] rem_reg,  rem_next;
    logic [DW-1:0] den_reg,  den_next;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          qbit;

    always_comb begin
        shifted   = {rem_reg, quot_reg[NW-1]};
        diff      = shifted - {1'b0, den_reg};
        qbit      = (shifted >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(NW - 1);
            quot_next = num;
            rem_next  = '0;
            den_next  = den;
        end else if (busy_reg) begin
            quot_next = {quot_reg[NW-2:0], qbit};
            rem_next  = qbit ? diff[DW-1:0] : shifted[DW-1:0];
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

[hdl/twc_acc.sv]
// ----------------------------------------------------------------------------
// twc_acc
// Running saturating sum and smallest nonzero value over a stream of bins.
// ----------------------------------------------------------------------------
module twc_acc #(
    parameter int COUNT_BITS = 32
) (
    input  logic                          aclk,
    input  twc_pkg::acc_ctrl_t            ctrl,
    input  logic [COUNT_BITS-1:0]         bin_value,
    output logic [twc_pkg::OUT_W-1:0]     sum,
    output logic [twc_pkg::OUT_W-1:0]     min_nonzero
);

    localparam int OW = twc_pkg::OUT_W;
    localparam int VW = (COUNT_BITS > OW) ? COUNT_BITS : OW;

    logic [OW-1:0]         sum_reg, sum_next;
    logic [COUNT_BITS-1:0] min_reg, min_next;
    logic [VW-1:0]         val_w;
    logic [VW-1:0]         min_w;
    logic [OW-1:0]         val_clip;
    logic [OW:0]           sum_wide;

    always_comb begin
        val_w    = VW'(bin_value);
        min_w    = VW'(min_reg);
        val_clip = (val_w > VW'({OW{1'b1}})) ? {OW{1'b1}} : val_w[OW-1:0];
        sum_wide = {1'b0, sum_reg} + {1'b0, val_clip};
        sum_next = sum_reg;
        min_next = min_reg;
        if (ctrl.clear) begin
            sum_next = '0;
            min_next = '0;
        end else if (ctrl.add) begin
            sum_next = sum_wide[OW] ? {OW{1'b1}} : sum_wide[OW-1:0];
            if (bin_value != '0 && (min_reg == '0 || bin_value < min_reg)) begin
                min_next = bin_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        min_reg <= min_next;
    end

    assign sum         = sum_reg;
    assign min_nonzero = (min_w > VW'({OW{1'b1}})) ? {OW{1'b1}} : min_w[OW-1:0];

endmodule

[hdl/time_binned_window_counter.sv]
// ----------------------------------------------------------------------------
// time_binned_window_counter
// Sliding window event counter over a ring of time bins held in a memory.
// ----------------------------------------------------------------------------
// Each input beat carries the current time and an amount. The block divides
// the time since its start by the bin length, moves the ring of bin counts
// forward to that bin (zeroing the bins it steps over, or the whole memory
// when the gap covers the window), adds the amount to the current bin with
// saturation and returns the window sum, the smallest nonzero bin and the
// current bin index. Time running backward restarts the ring at bin 0 and
// sets the restart flag. One beat is worked on at a time. Each item passes
// through two divisions in the shared bit-serial divider (bin number, then
// ring index; each gives a 48 bit quotient), a read-modify-write of the
// current bin, a walk over the w bins of the window, where w is the clamped
// window size, through the single read port of the bin memory, a drain of
// the last read, the load of the output register and the take of the next
// beat. Advancing by d bins adds one memory write per bin stepped over; a
// full wipe or a restart writes all MAX_BINS entries instead. After reset the
// block zeroes the whole bin memory with s_tready low; configuration writes
// are taken at any time. A finished result waits in the output register, so
// the next beat is accepted and worked on while the previous result is still
// pending.
// ----------------------------------------------------------------------------
module time_binned_window_counter #(
    parameter int MAX_BINS   = 64,
    parameter int COUNT_BITS = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [twc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [twc_pkg::LEN_W-1:0]          cfg_wdata,
    // Input stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: [47:0] now_us, [79:48] add_amount.
    input  logic [twc_pkg::S_TDATA_W-1:0]      s_tdata,
    // Result stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: [31:0] window_sum, [63:32] window_min_nonzero,
    // [69:64] current_bin, [70] time_restart, [71] zero.
    output logic [twc_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int NW    = twc_pkg::NOW_W;
    localparam int AW    = twc_pkg::AMT_W;
    localparam int OW    = twc_pkg::OUT_W;
    localparam int LW    = twc_pkg::LEN_W;
    localparam int IDX_W = $clog2(MAX_BINS);
    localparam int WIN_W = $clog2(MAX_BINS + 1);
    localparam int EXT_W = ((COUNT_BITS > AW) ? COUNT_BITS : AW) + 1;

    // Configuration registers.
    logic [LW-1:0]                  bin_len_reg;
    logic [twc_pkg::WCFG_W-1:0]     bins_cfg_reg;

    // Sequencer state.
    twc_pkg::twc_state_t state_reg, state_next;
    logic                 wipe_ret_reg, wipe_ret_next;
    logic [IDX_W-1:0]     ptr_reg, ptr_next;
    logic [WIN_W-1:0]     cnt_reg, cnt_next;
    logic                 rd_vld_reg;

    // Persistent ring state.
    logic [NW-1:0]        start_reg, start_next;
    logic [NW-1:0]        offset_reg, offset_next;

    // Item being worked on.
    logic [NW-1:0]        now_reg, now_next;
    logic [AW-1:0]        amount_reg, amount_next;
    logic [WIN_W-1:0]     win_reg, win_next;
    logic [NW-1:0]        quot_reg, quot_next;
    logic [NW-1:0]        dist_reg, dist_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 restart_reg, restart_next;

    // Output register.
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OW-1:0]        sum_out_reg, sum_out_next;
    logic [OW-1:0]        min_out_reg, min_out_next;
    logic [twc_pkg::BIN_OUT_W-1:0] bin_out_reg, bin_out_next;
    logic                 rst_out_reg, rst_out_next;

    // Divider, memory and accumulator connections.
    logic                 div_start;
    logic [NW-1:0]        div_num;
    logic [LW-1:0]        div_den;
    logic                 div_done;
    logic [NW-1:0]        div_quot;
    logic [LW-1:0]        div_rem;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;

    twc_pkg::acc_ctrl_t   acc_ctrl;
    logic [OW-1:0]        acc_sum;
    logic [OW-1:0]        acc_min;

    // Helpers.
    logic [NW-1:0]        s_now;
    logic [AW-1:0]        s_amount;
    logic [LW-1:0]        len_eff;
    logic [WIN_W-1:0]     win_eff;
    logic [IDX_W-1:0]     win_last;
    logic [EXT_W-1:0]     cmax_ext;
    logic [EXT_W-1:0]     amt_ext;
    logic [EXT_W-1:0]     amt_clip;
    logic [EXT_W-1:0]     bin_sum;
    logic [COUNT_BITS-1:0] bin_new;
    logic [31:0]          idx_wide;
    logic                 accept;

    assign s_now    = s_tdata[NW-1:0];
    assign s_amount = s_tdata[NW+AW-1:NW];
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == twc_pkg::ST_IDLE);

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_len_reg  <= twc_pkg::BIN_LENGTH_RST;
            bins_cfg_reg <= twc_pkg::BINS_IN_USE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                twc_pkg::CFG_BIN_LENGTH: begin
                    bin_len_reg <= cfg_wdata;
                end
                twc_pkg::CFG_BINS_IN_USE: begin
                    bins_cfg_reg <= cfg_wdata[twc_pkg::WCFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // A zero bin length counts as one microsecond; the window size is
    // clamped into 1..MAX_BINS.
    always_comb begin
        len_eff = (bin_len_reg == '0) ? LW'(1) : bin_len_reg;
        if (bins_cfg_reg == '0) begin
            win_eff = WIN_W'(1);
        end else if (32'(bins_cfg_reg) > 32'(MAX_BINS)) begin
            win_eff = WIN_W'(MAX_BINS);
        end else begin
            win_eff = WIN_W'(bins_cfg_reg);
        end
    end

    assign win_last = IDX_W'(win_reg - WIN_W'(1));

    // Saturating add of the amount to the bin read from memory.
    always_comb begin
        cmax_ext = EXT_W'({COUNT_BITS{1'b1}});
        amt_ext  = EXT_W'(amount_reg);
        amt_clip = (amt_ext > cmax_ext) ? cmax_ext : amt_ext;
        bin_sum  = EXT_W'(ram_rdata) + amt_clip;
        bin_new  = (bin_sum > cmax_ext) ? {COUNT_BITS{1'b1}} : bin_sum[COUNT_BITS-1:0];
    end

    assign idx_wide = 32'(idx_reg);

    // Sequencer: next state, memory port control and item bookkeeping.
    always_comb begin
        state_next    = state_reg;
        wipe_ret_next = wipe_ret_reg;
        ptr_next      = ptr_reg;
        cnt_next      = cnt_reg;
        start_next    = start_reg;
        offset_next   = offset_reg;
        now_next      = now_reg;
        amount_next   = amount_reg;
        win_next      = win_reg;
        quot_next     = quot_reg;
        dist_next     = dist_reg;
        idx_next      = idx_reg;
        restart_next  = restart_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        sum_out_next  = sum_out_reg;
        min_out_next  = min_out_reg;
        bin_out_next  = bin_out_reg;
        rst_out_next  = rst_out_reg;
        div_start     = 1'b0;
        div_num       = s_now - start_reg;
        div_den       = len_eff;
        ram_we        = 1'b0;
        ram_waddr     = ptr_reg;
        ram_wdata     = '0;
        ram_raddr     = ptr_reg;
        acc_ctrl      = '{clear: 1'b0, add: rd_vld_reg};

        case (state_reg)
            twc_pkg::ST_WIPE: begin
                // Zero every entry, including those outside the window.
                ram_we = 1'b1;
                if (ptr_reg == IDX_W'(MAX_BINS - 1)) begin
                    state_next = wipe_ret_reg ? twc_pkg::ST_READ : twc_pkg::ST_IDLE;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            twc_pkg::ST_IDLE: begin
                if (accept) begin
                    now_next     = s_now;
                    amount_next  = s_amount;
                    win_next     = win_eff;
                    restart_next = 1'b0;
                    div_start    = 1'b1;
                    state_next   = twc_pkg::ST_DIV_Q;
                end
            end
            twc_pkg::ST_DIV_Q: begin
                div_num = div_quot;
                div_den = LW'(win_reg);
                if (div_done) begin
                    if (now_reg < start_reg || div_quot < offset_reg) begin
                        // Time ran backward: restart the ring at bin 0.
                        start_next    = now_reg;
                        offset_next   = '0;
                        idx_next      = '0;
                        restart_next  = 1'b1;
                        ptr_next      = '0;
                        wipe_ret_next = 1'b1;
                        state_next    = twc_pkg::ST_WIPE;
                    end else begin
                        quot_next  = div_quot;
                        dist_next  = div_quot - offset_reg;
                        div_start  = 1'b1;
                        state_next = twc_pkg::ST_DIV_R;
                    end
                end
            end
            twc_pkg::ST_DIV_R: begin
                if (div_done) begin
                    idx_next    = div_rem[IDX_W-1:0];
                    offset_next = quot_reg;
                    if (dist_reg >= NW'(win_reg)) begin
                        ptr_next      = '0;
                        wipe_ret_next = 1'b1;
                        state_next    = twc_pkg::ST_WIPE;
                    end else if (dist_reg == '0) begin
                        state_next = twc_pkg::ST_READ;
                    end else begin
                        // Zero the bins stepped over, walking back from the
                        // new current bin.
                        ptr_next   = div_rem[IDX_W-1:0];
                        cnt_next   = dist_reg[WIN_W-1:0];
                        state_next = twc_pkg::ST_ADVANCE;
                    end
                end
            end
            twc_pkg::ST_ADVANCE: begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                ptr_next = (ptr_reg == '0) ? win_last : ptr_reg - 1'b1;
                if (cnt_reg == WIN_W'(1)) begin
                    state_next = twc_pkg::ST_READ;
                end
            end
            twc_pkg::ST_READ: begin
                ram_raddr  = idx_reg;
                state_next = twc_pkg::ST_WRITE;
            end
            twc_pkg::ST_WRITE: begin
                ram_we         = 1'b1;
                ram_waddr      = idx_reg;
                ram_wdata      = bin_new;
                acc_ctrl.clear = 1'b1;
                ptr_next       = '0;
                state_next     = twc_pkg::ST_SUM;
            end
            twc_pkg::ST_SUM: begin
                if (ptr_reg == win_last) begin
                    state_next = twc_pkg::ST_SUM_LAST;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            twc_pkg::ST_SUM_LAST: begin
                state_next = twc_pkg::ST_DONE;
            end
            twc_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    sum_out_next  = acc_sum;
                    min_out_next  = acc_min;
                    bin_out_next  = idx_wide[twc_pkg::BIN_OUT_W-1:0];
                    rst_out_next  = restart_reg;
                    state_next    = twc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = twc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= twc_pkg::ST_WIPE;
            wipe_ret_reg <= 1'b0;
            ptr_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            start_reg    <= '0;
            offset_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            wipe_ret_reg <= wipe_ret_next;
            ptr_reg      <= ptr_next;
            rd_vld_reg   <= (state_reg == twc_pkg::ST_SUM);
            m_tvalid_reg <= m_tvalid_next;
            start_reg    <= start_next;
            offset_reg   <= offset_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cnt_reg     <= cnt_next;
        now_reg     <= now_next;
        amount_reg  <= amount_next;
        win_reg     <= win_next;
        quot_reg    <= quot_next;
        dist_reg    <= dist_next;
        idx_reg     <= idx_next;
        restart_reg <= restart_next;
        sum_out_reg <= sum_out_next;
        min_out_reg <= min_out_next;
        bin_out_reg <= bin_out_next;
        rst_out_reg <= rst_out_next;
    end

    twc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    twc_ram #(
        .DEPTH (MAX_BINS),
        .WIDTH (COUNT_BITS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    twc_acc #(
        .COUNT_BITS (COUNT_BITS)
    ) u_acc (
        .aclk        (aclk),
        .ctrl        (acc_ctrl),
        .bin_value   (ram_rdata),
        .sum         (acc_sum),
        .min_nonzero (acc_min)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, rst_out_reg, bin_out_reg, min_out_reg, sum_out_reg};

endmodule

[test/time_binned_window_counter_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// time_binned_window_counter_test
// Self-checking bench for the time binned sliding window counter.
// ----------------------------------------------------------------------------
// Beats of (time, amount) are sent into the counter. A behavioral copy of the
// bin ring runs alongside and computes the window sum, the smallest nonzero
// bin, the ring index and the restart flag for every accepted beat. A monitor
// compares each result beat field by field with the oldest prediction. Short
// directed tests cover the default setup, the window size and bin length
// extremes, time running backward and window resizing. A long random test then
// drives mostly forward-moving time with random jumps, backward steps and
// saturating amounts over ten register settings. Both stream sides stall at
// random, except for one whole setting that runs without any gaps.
// ----------------------------------------------------------------------------
module time_binned_window_counter_test;

    // Generous bound on the whole run, far above the slowest legal run.
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RING_SIZE   = 64;

    // Expected content of one result beat.
    typedef struct packed {
        logic [twc_pkg::OUT_W-1:0]     window_sum;
        logic [twc_pkg::OUT_W-1:0]     window_min_nonzero;
        logic [twc_pkg::BIN_OUT_W-1:0] current_bin;
        logic                          time_restart;
    } window_report_t;

    // Every input of the block is at a known value from time zero.
    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [twc_pkg::CFG_IDX_W-1:0]  cfg_index = twc_pkg::CFG_BIN_LENGTH;
    logic [twc_pkg::LEN_W-1:0]      cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    // s_tdata: [47:0] now_us, [79:48] add_amount.
    logic [twc_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    // m_tdata: [31:0] window_sum, [63:32] window_min_nonzero,
    // [69:64] current_bin, [70] time_restart, [71] zero.
    logic [twc_pkg::M_TDATA_W-1:0]  m_tdata;

    // Our own copy of the counter state and its two registers.
    logic [31:0]                ring [RING_SIZE] = '{default: '0};
    logic [twc_pkg::NOW_W-1:0]  origin_us   = '0;   // time at which bin zero began
    logic [twc_pkg::NOW_W-1:0]  head_bin    = '0;   // absolute number of the newest bin
    logic [twc_pkg::LEN_W-1:0]  bin_len_cfg = twc_pkg::BIN_LENGTH_RST;
    logic [twc_pkg::WCFG_W-1:0] bins_cfg    = twc_pkg::BINS_IN_USE_RST;

    window_report_t pending_reports [$];
    window_report_t due;
    int             mismatches = 0;
    int             cycles     = 0;
    bit             steady_run = 1'b0;    // no stalls on either side while set
    logic [twc_pkg::NOW_W-1:0] clock_us = '0;   // time stamp of the random traffic

    // Register settings walked by the random test; out-of-range window sizes
    // and a zero bin length are included on purpose.
    logic [twc_pkg::LEN_W-1:0]  phase_bin_len [10] = '{32'd1, 32'd1, 32'd3, 32'd250,
                                                       32'd0, 32'd1000000, 32'hFFFF_FFFF,
                                                       32'd17, 32'd5, 32'd64};
    logic [twc_pkg::WCFG_W-1:0] phase_bins [10]    = '{7'd1, 7'd64, 7'd16, 7'd7, 7'd33,
                                                       7'd64, 7'd2, 7'd127, 7'd0, 7'd40};

    time_binned_window_counter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #6 aclk = ~aclk;

    // Watchdog: a hung block must not hang the run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[time_binned_window_counter] ERROR");
            $finish;
        end
    end

    // Outside a steady run the result side stalls in about a third of the cycles.
    always @(negedge aclk) begin
        m_tready <= steady_run || ($urandom_range(99) >= 32);
    end

    function automatic void wipe_ring();
        for (int j = 0; j < RING_SIZE; j++) ring[j] = '0;
    endfunction

    // Advances the bin ring to the time of one beat, adds the amount to the
    // current bin and returns what the block must report for that beat.
    function automatic window_report_t tally_event(
        input logic [twc_pkg::NOW_W-1:0] now,
        input logic [twc_pkg::AMT_W-1:0] amount);
        longint unsigned span, len, elapsed, slot, total;
        logic [twc_pkg::OUT_W-1:0] lowest;
        window_report_t   r;
        span = (bins_cfg == 0) ? 1 : ((bins_cfg > RING_SIZE) ? RING_SIZE : bins_cfg);
        len = (bin_len_cfg == 0) ? 1 : bin_len_cfg;
        elapsed = (now >= origin_us) ? (now - origin_us) / len : 0;
        r.time_restart = 1'b0;
        if (now < origin_us || elapsed < head_bin) begin
            // Time went backward: the ring starts over at this time stamp.
            wipe_ring();
            origin_us = now;
            head_bin = '0;
            r.time_restart = 1'b1;
            slot = 0;
        end else begin
            // A gap of a whole window or more clears everything at once.
            if (elapsed - head_bin >= span) begin
                head_bin = elapsed[twc_pkg::NOW_W-1:0];
                wipe_ring();
            end
            slot = elapsed % span;
            // Otherwise step bin by bin, zeroing each bin entered.
            for (int j = 0; j < span && (head_bin % span) != slot; j++) begin
                head_bin = head_bin + 1'b1;
                ring[head_bin % span] = '0;
            end
        end
        if (ring[slot] + 64'(amount) > 64'hFFFF_FFFF) ring[slot] = '1;
        else ring[slot] = ring[slot] + amount;
        total = 0;
        lowest = '0;
        for (int j = 0; j < span; j++) begin
            total = total + ring[j];
            if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
            if (ring[j] != 0 && (lowest == 0 || ring[j] < lowest)) lowest = ring[j];
        end
        r.window_sum = total[twc_pkg::OUT_W-1:0];
        r.window_min_nonzero = lowest;
        r.current_bin = slot[twc_pkg::BIN_OUT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string what, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // Result monitor: every accepted result beat is held against the oldest
    // prediction still waiting.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                mismatches++;
                $display("%0t ns: result beat with nothing expected, expected none, actual %h",
                         $time, m_tdata);
            end else begin
                due = pending_reports.pop_front();
                check_field("window_sum", due.window_sum, m_tdata[31:0]);
                check_field("window_min_nonzero", due.window_min_nonzero, m_tdata[63:32]);
                check_field("current_bin", due.current_bin, m_tdata[69:64]);
                check_field("time_restart", due.time_restart, m_tdata[70]);
            end
        end
    end

    // Sends one beat; called and returning at a falling edge. The valid stays
    // high into the next beat unless a random gap is taken before it.
    task automatic send_sample(input logic [twc_pkg::NOW_W-1:0] now,
                               input logic [twc_pkg::AMT_W-1:0] amount);
        int gap;
        if (!steady_run && $urandom_range(99) < 32) begin
            // Mostly short gaps, now and then one long enough to land anywhere
            // in the block's processing of the previous beat.
            gap = ($urandom_range(9) == 0) ? $urandom_range(20, 250) : $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {amount, now};
        do @(posedge aclk); while (!s_tready);
        pending_reports.push_back(tally_event(now, amount));
        @(negedge aclk);
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge aclk);
    endtask

    // Register writes only happen with the block idle.
    task automatic program_register(input logic [twc_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [twc_pkg::LEN_W-1:0] value);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == twc_pkg::CFG_BIN_LENGTH) bin_len_cfg = value;
        else bins_cfg = value[twc_pkg::WCFG_W-1:0];
        @(negedge aclk);
    endtask

    // Reset values: one second bins over 64 bins. Covers a query of the empty
    // ring, a full-scale amount, bin saturation and the ring wrapping around.
    task automatic test_default_setup();
        send_sample(48'd0, 32'd0);
        send_sample(48'd0, 32'hFFFF_FFFF);
        send_sample(48'd999_999, 32'd1);
        send_sample(48'd1_000_000, 32'd5);
        send_sample(48'd64_000_000, 32'd2);
    endtask

    // Single-bin window, then a window size of zero and of 127 (both clamped)
    // and finally a bin length of zero, which acts as one microsecond.
    task automatic test_window_extremes();
        program_register(twc_pkg::CFG_BIN_LENGTH, 32'd1);
        program_register(twc_pkg::CFG_BINS_IN_USE, 32'd1);
        send_sample(48'd70_000_000, 32'd3);
        send_sample(48'd70_000_000, 32'd4);
        program_register(twc_pkg::CFG_BINS_IN_USE, 32'd0);
        send_sample(48'd70_000_001, 32'd0);
        program_register(twc_pkg::CFG_BINS_IN_USE, 32'd127);
        send_sample(48'd70_000_002, 32'd9);
        program_register(twc_pkg::CFG_BIN_LENGTH, 32'd0);
        send_sample(48'd70_000_003, 32'd1);
        send_sample(48'd70_000_070, 32'd1);
    endtask

    // Time stamp at the top of its range, then a jump back to zero, then a
    // restart caused by a longer bin length pushing the bin number below the
    // newest bin.
    task automatic test_time_backward();
        program_register(twc_pkg::CFG_BIN_LENGTH, 32'd10);
        program_register(twc_pkg::CFG_BINS_IN_USE, 32'd8);
        send_sample(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFE);
        send_sample(48'd0, 32'd1);
        send_sample(48'd35, 32'd2);
        program_register(twc_pkg::CFG_BIN_LENGTH, 32'd1000);
        send_sample(48'd40, 32'd3);
        send_sample(48'd40, 32'd0);
    endtask

    // Bins left outside a shrunken window keep their counts and show up again
    // once the window grows back.
    task automatic test_window_resize();
        program_register(twc_pkg::CFG_BIN_LENGTH, 32'd1);
        program_register(twc_pkg::CFG_BINS_IN_USE, 32'd8);
        for (int k = 0; k < 6; k++) send_sample(48'd100 + k, 32'(k + 1));
        program_register(twc_pkg::CFG_BINS_IN_USE, 32'd2);
        send_sample(48'd105, 32'd0);
        program_register(twc_pkg::CFG_BINS_IN_USE, 32'd8);
        send_sample(48'd106, 32'd0);
    endtask

    // Random traffic over ten settings. Time mostly moves forward by less than
    // a window so that bins fill up and get stepped over; jumps to arbitrary
    // time stamps, backward steps and repeated time stamps are mixed in.
    task automatic test_random_traffic();
        logic [63:0]               wide;
        logic [twc_pkg::AMT_W-1:0] amount;
        longint unsigned           len, span, step;
        int                        pick;
        for (int p = 0; p < 10; p++) begin
            program_register(twc_pkg::CFG_BIN_LENGTH, phase_bin_len[p]);
            program_register(twc_pkg::CFG_BINS_IN_USE, {25'd0, phase_bins[p]});
            steady_run = (p == 5);
            len = (bin_len_cfg == 0) ? 1 : bin_len_cfg;
            span = (bins_cfg == 0) ? 1 : ((bins_cfg > RING_SIZE) ? RING_SIZE : bins_cfg);
            for (int n = 0; n < 130; n++) begin
                pick = $urandom_range(99);
                if (pick < 50) begin
                    step = $urandom_range(3) * len + {$urandom} % len;
                    wide = clock_us + step;
                    clock_us = wide[twc_pkg::NOW_W-1:0];
                end else if (pick < 70) begin
                    step = $urandom_range(0, 2 * span) * len;
                    wide = clock_us + step;
                    clock_us = wide[twc_pkg::NOW_W-1:0];
                end else if (pick < 78) begin
                    wide = {$urandom, $urandom};
                    clock_us = wide[twc_pkg::NOW_W-1:0];
                end else if (pick < 86) begin
                    step = $urandom_range(1, 1000);
                    wide = clock_us - step;
                    clock_us = (clock_us > step) ? wide[twc_pkg::NOW_W-1:0] : '0;
                end else if (pick < 90) begin
                    clock_us = clock_us >> $urandom_range(1, 8);
                end
                pick = $urandom_range(99);
                if (pick < 20) amount = '0;
                else if (pick < 30) amount = 32'hFFFF_FFFF - $urandom_range(3);
                else if (pick < 45) amount = $urandom;
                else amount = $urandom_range(1, 1000);
                send_sample(clock_us, amount);
            end
        end
        steady_run = 1'b0;
    endtask

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        test_default_setup();
        test_window_extremes();
        test_time_backward();
        test_window_resize();
        test_random_traffic();
        // Let the last results drain and give the block time to show any
        // stray beat before the verdict.
        settle();
        repeat (400) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[time_binned_window_counter] OK");
        end else begin
            $display("[time_binned_window_counter] ERROR");
        end
        $finish;
    end

endmodule
